>>> hw/rtl/sample_rms_meter_defines.svh
// assertion macros used by the rms meter sequencer
`ifndef SAMPLE_RMS_METER_DEFINES_SVH
`define SAMPLE_RMS_METER_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SRM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/srm_pkg.sv
package srm_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 65536;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COUNT_W  = 17;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned RMS_W    = 24;
  localparam int unsigned QUO_W    = 64;
  localparam int unsigned ROOT_W   = 32;
  localparam int unsigned REM_W    = 34;
  localparam int unsigned UNIT_W   = 36;
  localparam int unsigned FMT_W    = 2;

  typedef enum logic [FMT_W-1:0] {
    FMT_S8  = 2'd0,
    FMT_U8  = 2'd1,
    FMT_U16 = 2'd2,
    FMT_S16 = 2'd3
  } fmt_t;

  localparam fmt_t FMT_RESET = FMT_S16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROOT
  } seq_state_t;

  typedef logic [FMT_W-1:0] cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_bits;
    logic                last_sample;
  } sample_t;

  typedef struct packed {
    logic [RMS_W-1:0]   rms_value;
    logic [COUNT_W-1:0] sample_count;
    logic               overflow_flag;
  } result_t;

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
    logic               ovf;
  } run_t;

endpackage

>>> hw/rtl/srm_stream_if.sv
interface srm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/srm_step_unit.sv
module srm_step_unit (
  input  logic [srm_pkg::UNIT_W-1:0] a,
  input  logic [srm_pkg::UNIT_W-1:0] b,
  output logic                       ge,
  output logic [srm_pkg::UNIT_W-1:0] diff
);
  import srm_pkg::*;

  logic borrow;

  // shared compare and subtract for divide and root steps
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};
  assign ge = !borrow;
endmodule

>>> hw/rtl/srm_accum.sv
module srm_accum #(
  parameter int unsigned MAX_SAMPLES = srm_pkg::MAX_SAMPLES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  srm_pkg::fmt_t    sample_format,
  input  logic             in_valid,
  input  srm_pkg::sample_t in_data,
  output logic             in_ready,
  input  logic             run_ready,
  output logic             run_start,
  output srm_pkg::run_t    run
);
  import srm_pkg::*;

  logic [SUM_W-1:0]      sum;
  logic [COUNT_W-1:0]    count;
  logic                  ovf;
  logic [SAMPLE_W-1:0]   mag;
  logic [2*SAMPLE_W-1:0] sq;
  logic                  full;
  logic                  accept;

  function automatic logic [SAMPLE_W-1:0] magnitude(input fmt_t fmt,
                                                    input logic [SAMPLE_W-1:0] raw);
    logic [7:0]          b8;
    logic [SAMPLE_W-1:0] m;
    b8 = raw[7:0];
    unique case (fmt)
      FMT_S8:  m = {8'h00, (b8[7] ? 8'(~b8 + 8'd1) : b8)};
      FMT_U8:  m = {8'h00, b8};
      FMT_U16: m = raw;
      FMT_S16: m = raw[SAMPLE_W-1] ? SAMPLE_W'(~raw + 16'd1) : raw;
      default: m = raw;
    endcase
    return m;
  endfunction

  assign in_ready = run_ready;
  assign accept   = in_valid && run_ready;
  assign mag      = magnitude(sample_format, in_data.sample_bits);
  assign sq       = mag * mag;
  assign full     = count >= COUNT_W'(MAX_SAMPLES);

  // running totals including the beat being taken, unless the count is full, which sets overflow
  always_comb begin
    run.sum   = full ? sum : sum + {{(SUM_W-2*SAMPLE_W){1'b0}}, sq};
    run.count = full ? count : count + 1'b1;
    run.ovf   = ovf | full;
  end

  assign run_start = accept && in_data.last_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
      ovf   <= 1'b0;
    end else if (accept) begin
      if (in_data.last_sample) begin
        sum   <= '0;
        count <= '0;
        ovf   <= 1'b0;
      end else begin
        sum   <= run.sum;
        count <= run.count;
        ovf   <= run.ovf;
      end
    end
  end
endmodule

>>> hw/rtl/srm_seq.sv
`include "sample_rms_meter_defines.svh"

module srm_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             run_start,
  input  srm_pkg::run_t    run,
  output logic             run_ready,
  output logic             res_valid,
  input  logic             res_ready,
  output srm_pkg::result_t res
);
  import srm_pkg::*;

  localparam int unsigned STEP_W = $clog2(QUO_W);

  seq_state_t           state, state_next;
  logic [STEP_W-1:0]    step, step_next;
  logic [QUO_W-1:0]     work;
  logic [REM_W-1:0]     rem;
  logic [ROOT_W-1:0]    root;
  logic [ROOT_W-1:0]    root_next;
  logic [COUNT_W-1:0]   divisor;
  logic                 ovf_l;
  logic [UNIT_W-1:0]    op_a, op_b, diff;
  logic                 ge;
  logic                 div_last, root_last, out_free, advance, finish;

  srm_step_unit u_step (
    .a    (op_a),
    .b    (op_b),
    .ge   (ge),
    .diff (diff)
  );

  assign div_last  = step == STEP_W'(QUO_W - 1);
  assign root_last = step == STEP_W'(ROOT_W - 1);
  assign out_free  = !res_valid || res_ready;
  assign root_next = {root[ROOT_W-2:0], ge};
  assign run_ready = state == ST_IDLE;

  // operand select for the shared unit
  always_comb begin
    if (state == ST_ROOT) begin
      op_a = {rem, work[QUO_W-1 -: 2]};
      op_b = {{(UNIT_W-ROOT_W-2){1'b0}}, root, 2'b01};
    end else begin
      op_a = {{(UNIT_W-COUNT_W-1){1'b0}}, rem[COUNT_W-1:0], work[QUO_W-1]};
      op_b = {{(UNIT_W-COUNT_W){1'b0}}, divisor};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    advance    = 1'b0;
    finish     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (run_start) begin
          state_next = ST_DIV;
          step_next  = '0;
        end
      end
      ST_DIV: begin
        advance   = 1'b1;
        step_next = step + 1'b1;
        if (div_last) begin
          state_next = ST_ROOT;
          step_next  = '0;
        end
      end
      ST_ROOT: begin
        advance = !root_last || out_free;
        if (advance) begin
          step_next = step + 1'b1;
          if (root_last) begin
            finish     = 1'b1;
            state_next = ST_IDLE;
            step_next  = '0;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
        step_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && run_start) begin
      work    <= {run.sum, 16'h0000};
      rem     <= '0;
      divisor <= run.count;
      ovf_l   <= run.ovf;
    end else if (advance) begin
      if (state == ST_DIV) begin
        work <= {work[QUO_W-2:0], ge};
        if (div_last) begin
          rem  <= '0;
          root <= '0;
        end else begin
          rem <= ge ? diff[REM_W-1:0] : op_a[REM_W-1:0];
        end
      end else begin
        rem  <= ge ? diff[REM_W-1:0] : op_a[REM_W-1:0];
        work <= {work[QUO_W-3:0], 2'b00};
        root <= root_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      res.rms_value     <= root_next[RMS_W-1:0];
      res.sample_count  <= divisor;
      res.overflow_flag <= ovf_l;
    end
  end

  `SRM_ASSERT_IMPL(a_start_idle, run_start, state == ST_IDLE, "run started while busy")
  `SRM_ASSERT_IMPL(a_div_rem, state == ST_DIV, rem < REM_W'(divisor), "remainder not below divisor")
  `SRM_ASSERT_NEXT(a_finish, finish, res_valid && state == ST_IDLE, "result not loaded at finish")
endmodule

>>> hw/rtl/sample_rms_meter.sv
// sample beats: one per cycle while ready, squared and summed in the accept cycle
// last beat of a run: 64 divide steps then 32 root steps on one shared subtractor,
// result registered at the final root step, input not ready from the last beat until then
// the final root step waits while a previous result is still untaken
// reset: format to signed 16-bit, sum, count and overflow cleared, no result pending
module sample_rms_meter #(
  parameter int unsigned MAX_SAMPLES = srm_pkg::MAX_SAMPLES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  srm_stream_if.sink   cfg,
  srm_stream_if.sink   sample,
  srm_stream_if.source result
);
  import srm_pkg::*;

  fmt_t    sample_format;
  logic    run_ready;
  logic    run_start;
  run_t    run;
  logic    res_valid;
  result_t res;
  sample_t in_data;
  cfg_t    cfg_data;

  assign cfg.ready = 1'b1;
  assign cfg_data  = cfg.payload;
  assign in_data   = sample.payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FMT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      sample_format <= fmt_t'(cfg_data);
    end
  end

  srm_accum #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_accum (
    .clk           (clk),
    .rst           (rst),
    .sample_format (sample_format),
    .in_valid      (sample.valid),
    .in_data       (in_data),
    .in_ready      (sample.ready),
    .run_ready     (run_ready),
    .run_start     (run_start),
    .run           (run)
  );

  srm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .run_start (run_start),
    .run       (run),
    .run_ready (run_ready),
    .res_valid (res_valid),
    .res_ready (result.ready),
    .res       (res)
  );

  assign result.valid   = res_valid;
  assign result.payload = res;
endmodule
